@@ sv/spr_pkg.sv @@
// shared types, constants and helpers for the stereo plate reverb
package spr_pkg;

	localparam int DATA_W = 24;
	localparam int COEF_W = 16;
	localparam int FB_W = 15;
	localparam int CNT_W = 3;
	localparam int SUM_W = 36;
	localparam int ACC_W = 50;
	localparam int IDX_W = 8;

	localparam logic [COEF_W-1:0] Q_ONE = 16'd32768;

	localparam logic [IDX_W-1:0] REG_MIX = 8'd0;
	localparam logic [IDX_W-1:0] REG_COMB_FB = 8'd1;
	localparam logic [IDX_W-1:0] REG_DAMPING = 8'd2;
	localparam logic [IDX_W-1:0] REG_TONE = 8'd3;

	localparam logic [COEF_W-1:0] MIX_RST = 16'd11469;
	localparam logic [FB_W-1:0] FB_RST = 15'd24574;
	localparam logic [COEF_W-1:0] DAMP_RST = 16'd16384;
	localparam logic [COEF_W-1:0] TONE_RST = 16'd18022;

	typedef struct packed {
		logic issue;
		logic clr;
		logic neg;
	} mac_ctl_t;

	function automatic logic [COEF_W-1:0] clamp_one(input logic [COEF_W-1:0] c);
		return (c > Q_ONE) ? Q_ONE : c;
	endfunction

	function automatic logic [COEF_W-1:0] ap_gain(input logic [CNT_W-1:0] i);
		logic [COEF_W-1:0] g;
		case (i)
			3'd0: g = 16'd24576;
			3'd1: g = 16'd26214;
			3'd2: g = 16'd27853;
			3'd3: g = 16'd29491;
			default: g = 16'd31130;
		endcase
		return g;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [31:0] r;
		if (v > 37'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -37'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat24(input logic signed [31:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 32'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -32'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ sv/spr_mac.sv @@
// shared multiply-accumulate unit with q15 rounding and 32-bit saturation
module spr_mac import spr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  mac_ctl_t            ctl,
	input  logic signed [32:0]  a,
	input  logic signed [16:0]  b,
	input  logic signed [32:0]  addend,
	output logic signed [31:0]  result
);

	logic signed [ACC_W-1:0] prod_s1;
	logic                    issue_s1;
	logic                    clr_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] biased;
	logic signed [34:0]      rnd;
	logic signed [36:0]      total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			clr_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
			clr_s1 <= ctl.clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (issue_s1) begin
			acc_q <= clr_s1 ? prod_s1 : acc_q + prod_s1;
		end
	end

	// floor((acc + 16384) / 32768), then add or subtract from the addend
	always_comb begin
		biased = acc_q + 50'sd16384;
		rnd = 35'(biased >>> 15);
		if (ctl.neg) begin
			total = 37'(addend) - 37'(rnd);
		end else begin
			total = 37'(addend) + 37'(rnd);
		end
		result = sat32(total);
	end

endmodule

@@ sv/spr_div.sv @@
// divider of the comb sum by a small constant, truncating toward zero
module spr_div import spr_pkg::*; #(
	parameter int DIVISOR = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	output logic                    done,
	output logic signed [31:0]      quotient
);

	// floor(n / DIVISOR) equals (n * RECIP) >> SHIFT for every magnitude below 2**SUM_W
	localparam int SHIFT = SUM_W + 3;
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam int HALF_W = 20;
	localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
	localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];
	localparam int PROD_W = SUM_W + HALF_W;
	localparam int MUL_ACC_W = PROD_W + HALF_W;

	logic [SUM_W-1:0]     mag_q;
	logic                 neg_q;
	logic                 busy_q;
	logic                 hi_q;
	logic                 done_q;
	logic [MUL_ACC_W-1:0] acc_q;
	logic [HALF_W-1:0]    coef;
	logic [PROD_W-1:0]    prod;
	logic [31:0]          qmag;

	// low half of the reciprocal first, then the high half shifted up
	assign coef = hi_q ? RECIP_HI : RECIP_LO;
	assign prod = PROD_W'(mag_q) * PROD_W'(coef);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hi_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				hi_q <= 1'b0;
			end else if (busy_q) begin
				if (hi_q) begin
					busy_q <= 1'b0;
					hi_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					hi_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
		end else if (busy_q) begin
			if (hi_q) begin
				acc_q <= acc_q + {prod, {HALF_W{1'b0}}};
			end else begin
				acc_q <= MUL_ACC_W'(prod);
			end
		end
	end

	assign qmag = acc_q[SHIFT +: 32];
	assign done = done_q;
	assign quotient = neg_q ? -qmag : qmag;

endmodule

@@ sv/stereo_plate_reverb.sv @@
// stereo plate reverb: comb bank, allpass chain, tone lowpass and dry/wet mix
// the shared multiply-accumulate unit and the comb-sum divider are walked step by step for
//   each channel in turn; a new item is taken only once the last result has been loaded,
//   and a stalled result holds off the next item
// reset: registers return to defaults, delay lines read as zero until each ring
//   position has been written once, no clearing pass is needed
module stereo_plate_reverb import spr_pkg::*; #(
	parameter int COMB_LENGTH = 1500,
	parameter int ALLPASS_LENGTH = 600,
	parameter int COMB_COUNT = 3,
	parameter int ALLPASS_COUNT = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [47:0]      s_tdata,  // left_in [23:0], right_in [47:24]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,  // left_out [23:0], right_out [47:24]
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int COMB_WORDS = 2 * COMB_COUNT * COMB_LENGTH;
	localparam int AP_WORDS = 2 * ALLPASS_COUNT * ALLPASS_LENGTH;
	localparam int CA_W = (COMB_WORDS > 1) ? $clog2(COMB_WORDS) : 1;
	localparam int AA_W = (AP_WORDS > 1) ? $clog2(AP_WORDS) : 1;
	localparam int CP_W = (COMB_LENGTH > 1) ? $clog2(COMB_LENGTH) : 1;
	localparam int AP_W = (ALLPASS_LENGTH > 1) ? $clog2(ALLPASS_LENGTH) : 1;
	localparam int LP_N = 2 * COMB_COUNT;
	localparam int LP_W = $clog2(LP_N);

	typedef enum logic [24:0] {
		S_IDLE = 25'd1 << 0,
		S_CRD  = 25'd1 << 1,
		S_LP1  = 25'd1 << 2,
		S_LP2  = 25'd1 << 3,
		S_LPW  = 25'd1 << 4,
		S_LPR  = 25'd1 << 5,
		S_FB   = 25'd1 << 6,
		S_FBW  = 25'd1 << 7,
		S_CWR  = 25'd1 << 8,
		S_DIV  = 25'd1 << 9,
		S_ARD  = 25'd1 << 10,
		S_AB   = 25'd1 << 11,
		S_ABW  = 25'd1 << 12,
		S_ANW  = 25'd1 << 13,
		S_AG   = 25'd1 << 14,
		S_AGW  = 25'd1 << 15,
		S_AOUT = 25'd1 << 16,
		S_TONE = 25'd1 << 17,
		S_TW   = 25'd1 << 18,
		S_TOUT = 25'd1 << 19,
		S_MIX1 = 25'd1 << 20,
		S_MIX2 = 25'd1 << 21,
		S_MW   = 25'd1 << 22,
		S_MOUT = 25'd1 << 23,
		S_OUT  = 25'd1 << 24
	} state_t;

	state_t state_q;

	logic [COEF_W-1:0] mix_q;
	logic [FB_W-1:0]   fb_q;
	logic [COEF_W-1:0] damp_q;
	logic [COEF_W-1:0] tone_coef_q;

	logic signed [31:0] comb_mem [COMB_WORDS];
	logic signed [31:0] ap_mem [AP_WORDS];
	logic signed [31:0] comb_rd_q;
	logic signed [31:0] ap_rd_q;
	logic [CA_W-1:0]    comb_addr_q;
	logic [AA_W-1:0]    ap_addr_q;
	logic [CP_W-1:0]    comb_pos_q;
	logic [AP_W-1:0]    ap_pos_q;
	logic               comb_full_q;
	logic               ap_full_q;

	logic signed [31:0]       lp_q [LP_N];
	logic signed [31:0]       tone_q [2];
	logic [LP_W-1:0]          lp_idx_q;
	logic [CNT_W-1:0]         c_q;
	logic                     ch_q;
	logic signed [DATA_W-1:0] dry_l_q;
	logic signed [DATA_W-1:0] dry_r_q;
	logic signed [31:0]       y_q;
	logic signed [31:0]       b_q;
	logic signed [31:0]       w_q;
	logic signed [31:0]       res_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [DATA_W-1:0] left_res_q;
	logic signed [DATA_W-1:0] right_res_q;
	logic                     m_tvalid_q;
	logic [47:0]              m_tdata_q;

	logic [COEF_W-1:0]  damp_c;
	logic [COEF_W-1:0]  mix_c;
	logic [COEF_W-1:0]  tone_c;
	logic [COEF_W-1:0]  gain;
	logic signed [31:0] y_rd;
	logic signed [31:0] b_rd;
	logic signed [31:0] x;
	logic signed [31:0] lp_cur;
	logic signed [31:0] tone_cur;
	logic               load_out;

	mac_ctl_t           mac_ctl;
	logic signed [32:0] mac_a;
	logic signed [16:0] mac_b;
	logic signed [32:0] mac_addend;
	logic signed [31:0] mac_res;

	logic               div_start;
	logic               div_done;
	logic signed [31:0] div_q;

	assign damp_c = clamp_one(damp_q);
	assign mix_c = clamp_one(mix_q);
	assign tone_c = clamp_one(tone_coef_q);
	assign gain = ap_gain(c_q);
	assign y_rd = comb_full_q ? comb_rd_q : 32'sd0;
	assign b_rd = ap_full_q ? ap_rd_q : 32'sd0;
	assign x = ch_q ? 32'(dry_r_q) : 32'(dry_l_q);
	assign lp_cur = lp_q[lp_idx_q];
	assign tone_cur = tone_q[ch_q];
	assign s_tready = (state_q == S_IDLE);
	assign load_out = (state_q == S_OUT) && (!m_tvalid_q || m_tready);
	assign div_start = (state_q == S_CWR) && (c_q == CNT_W'(COMB_COUNT - 1));
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	spr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.addend (mac_addend),
		.result (mac_res)
	);

	spr_div #(
		.DIVISOR (COMB_COUNT)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// operand selection for the shared unit
	always_comb begin
		mac_ctl = '0;
		mac_a = '0;
		mac_b = '0;
		mac_addend = '0;
		unique case (state_q)
			S_LP1: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a = 33'(lp_cur);
				mac_b = {1'b0, Q_ONE - damp_c};
			end
			S_LP2: begin
				mac_ctl.issue = 1'b1;
				mac_a = 33'(y_q);
				mac_b = {1'b0, damp_c};
			end
			S_FB: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a = 33'(lp_cur);
				mac_b = {2'b00, fb_q};
			end
			S_CWR: mac_addend = 33'(x);
			S_AB: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a = 33'(b_rd);
				mac_b = {1'b0, gain};
			end
			S_ANW: mac_addend = 33'(w_q);
			S_AG: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a = 33'(res_q);
				mac_b = {1'b0, gain};
			end
			S_AOUT: begin
				mac_ctl.neg = 1'b1;
				mac_addend = 33'(b_q);
			end
			S_TONE: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a = 33'(w_q) - 33'(tone_cur);
				mac_b = {1'b0, tone_c};
			end
			S_TOUT: mac_addend = 33'(tone_cur);
			S_MIX1: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.clr = 1'b1;
				mac_a = 33'(x);
				mac_b = {1'b0, Q_ONE - mix_c};
			end
			S_MIX2: begin
				mac_ctl.issue = 1'b1;
				mac_a = 33'(tone_cur);
				mac_b = {1'b0, mix_c};
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= MIX_RST;
			fb_q <= FB_RST;
			damp_q <= DAMP_RST;
			tone_coef_q <= TONE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIX: mix_q <= cfg_data;
				REG_COMB_FB: fb_q <= cfg_data[FB_W-1:0];
				REG_DAMPING: damp_q <= cfg_data;
				REG_TONE: tone_coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// delay memories, registered reads
	always_ff @(posedge clk) begin
		if (state_q == S_CWR) begin
			comb_mem[comb_addr_q] <= mac_res;
		end
		comb_rd_q <= comb_mem[comb_addr_q];
		if (state_q == S_ANW) begin
			ap_mem[ap_addr_q] <= mac_res;
		end
		ap_rd_q <= ap_mem[ap_addr_q];
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			comb_pos_q <= '0;
			ap_pos_q <= '0;
			comb_full_q <= 1'b0;
			ap_full_q <= 1'b0;
			ch_q <= 1'b0;
			c_q <= '0;
			lp_idx_q <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < LP_N; i++) begin
				lp_q[i] <= '0;
			end
			tone_q[0] <= '0;
			tone_q[1] <= '0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ch_q <= 1'b0;
						c_q <= '0;
						lp_idx_q <= '0;
						state_q <= S_CRD;
					end
				end
				S_CRD: state_q <= S_LP1;
				S_LP1: state_q <= S_LP2;
				S_LP2: state_q <= S_LPW;
				S_LPW: state_q <= S_LPR;
				S_LPR: begin
					lp_q[lp_idx_q] <= mac_res;
					state_q <= S_FB;
				end
				S_FB: state_q <= S_FBW;
				S_FBW: state_q <= S_CWR;
				S_CWR: begin
					lp_idx_q <= (lp_idx_q == LP_W'(LP_N - 1)) ? '0 : lp_idx_q + LP_W'(1);
					if (c_q == CNT_W'(COMB_COUNT - 1)) begin
						c_q <= '0;
						state_q <= S_DIV;
					end else begin
						c_q <= c_q + CNT_W'(1);
						state_q <= S_CRD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ARD;
					end
				end
				S_ARD: state_q <= S_AB;
				S_AB: state_q <= S_ABW;
				S_ABW: state_q <= S_ANW;
				S_ANW: state_q <= S_AG;
				S_AG: state_q <= S_AGW;
				S_AGW: state_q <= S_AOUT;
				S_AOUT: begin
					if (c_q == CNT_W'(ALLPASS_COUNT - 1)) begin
						c_q <= '0;
						state_q <= S_TONE;
					end else begin
						c_q <= c_q + CNT_W'(1);
						state_q <= S_ARD;
					end
				end
				S_TONE: state_q <= S_TW;
				S_TW: state_q <= S_TOUT;
				S_TOUT: begin
					tone_q[ch_q] <= mac_res;
					state_q <= S_MIX1;
				end
				S_MIX1: state_q <= S_MIX2;
				S_MIX2: state_q <= S_MW;
				S_MW: state_q <= S_MOUT;
				S_MOUT: begin
					if (!ch_q) begin
						ch_q <= 1'b1;
						state_q <= S_CRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						// rings advance once per item; a full lap marks the store as written
						if (comb_pos_q == CP_W'(COMB_LENGTH - 1)) begin
							comb_pos_q <= '0;
							comb_full_q <= 1'b1;
						end else begin
							comb_pos_q <= comb_pos_q + CP_W'(1);
						end
						if (ap_pos_q == AP_W'(ALLPASS_LENGTH - 1)) begin
							ap_pos_q <= '0;
							ap_full_q <= 1'b1;
						end else begin
							ap_pos_q <= ap_pos_q + AP_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			dry_l_q <= s_tdata[23:0];
			dry_r_q <= s_tdata[47:24];
			comb_addr_q <= CA_W'(comb_pos_q);
			ap_addr_q <= AA_W'(ap_pos_q);
			sum_q <= '0;
		end
		if (state_q == S_LP1) begin
			y_q <= y_rd;
			sum_q <= sum_q + SUM_W'(y_rd);
		end
		if (state_q == S_CWR) begin
			comb_addr_q <= comb_addr_q + CA_W'(COMB_LENGTH);
		end
		if (state_q == S_DIV && div_done) begin
			w_q <= div_q;
		end
		if (state_q == S_AB) begin
			b_q <= b_rd;
		end
		if (state_q == S_ANW) begin
			res_q <= mac_res;
		end
		if (state_q == S_AOUT) begin
			w_q <= mac_res;
			ap_addr_q <= ap_addr_q + AA_W'(ALLPASS_LENGTH);
		end
		if (state_q == S_MOUT) begin
			sum_q <= '0;
			if (!ch_q) begin
				left_res_q <= sat24(mac_res);
			end else begin
				right_res_q <= sat24(mac_res);
			end
		end
		if (load_out) begin
			m_tdata_q <= {right_res_q, left_res_q};
		end
	end

endmodule

@@ sv/spr_checker.sv @@
// port-level checks for the stereo plate reverb
module spr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: busy right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// a new result only appears at the end of an item's processing
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

	// no result can follow an accepted item in the next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

bind stereo_plate_reverb spr_checker u_spr_checker (.*);
